FILE: sv/yuvcv_pkg.sv
`default_nettype none

package yuvcv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int MIN_WIDTH  = 16;
    localparam int MIN_HEIGHT = 2;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    localparam int SAMPLE_W = 8;
    localparam int CHROMA_W = 2 * SAMPLE_W;
    localparam int TDATA_W  = 4 * SAMPLE_W;

    localparam int WTMP_W = ($clog2(MAX_WIDTH) + 1 > CFG_DATA_W) ?
                            $clog2(MAX_WIDTH) + 1 : CFG_DATA_W;
    localparam int HTMP_W = ($clog2(MAX_HEIGHT) + 1 > CFG_DATA_W) ?
                            $clog2(MAX_HEIGHT) + 1 : CFG_DATA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [COL_W:0] pair_count_t;
    typedef logic [ROW_W:0] row_count_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             odd;
        logic             row_last;
        logic             frame_last;
    } pos_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] luma_left;
        logic [SAMPLE_W-1:0] cr;
        logic [SAMPLE_W-1:0] luma_right;
        logic                row_last;
        logic                frame_last;
    } out_item_t;

    function automatic pair_count_t calc_pairs(input logic [CFG_DATA_W-1:0] w);
        logic [WTMP_W-1:0] wm;
        wm = WTMP_W'({w[CFG_DATA_W-1:4], 4'b0000});
        if (wm < WTMP_W'(MIN_WIDTH)) begin
            wm = WTMP_W'(MIN_WIDTH);
        end
        if (wm > WTMP_W'(MAX_WIDTH)) begin
            wm = WTMP_W'(MAX_WIDTH);
        end
        return pair_count_t'(wm >> 1);
    endfunction

    function automatic row_count_t calc_rows(input logic [CFG_DATA_W-1:0] h);
        logic [HTMP_W-1:0] hm;
        hm = HTMP_W'({h[CFG_DATA_W-1:1], 1'b0});
        if (hm < HTMP_W'(MIN_HEIGHT)) begin
            hm = HTMP_W'(MIN_HEIGHT);
        end
        if (hm > HTMP_W'(MAX_HEIGHT)) begin
            hm = HTMP_W'(MAX_HEIGHT);
        end
        return row_count_t'(hm);
    endfunction

endpackage

`default_nettype wire

FILE: sv/yuvcv_seq.sv
`default_nettype none

module yuvcv_seq
    import yuvcv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  advance,
    output pos_t                       pos
);

    pair_count_t      pairs_reg, pairs_next;
    row_count_t       rows_reg, rows_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pair_count_t      col_inc;
    row_count_t       row_inc;
    logic             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign col_inc = {1'b0, col_reg} + pair_count_t'(1);
    assign row_inc = {1'b0, row_reg} + row_count_t'(1);

    assign pos.col        = col_reg;
    assign pos.odd        = row_reg[0];
    assign pos.row_last   = (col_inc >= pairs_reg);
    assign pos.frame_last = pos.row_last && (row_inc >= rows_reg);

    always_comb begin
        pairs_next = pairs_reg;
        rows_next  = rows_reg;
        if (cfg_we) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                pairs_next = calc_pairs(cfg_data);
            end
            if (cfg_index == CFG_FRAME_HEIGHT) begin
                rows_next = calc_rows(cfg_data);
            end
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (pos.row_last) begin
                col_next = '0;
                if (pos.frame_last) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_reg <= calc_pairs(CFG_DATA_W'(RESET_WIDTH));
            rows_reg  <= calc_rows(CFG_DATA_W'(RESET_HEIGHT));
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            pairs_reg <= pairs_next;
            rows_reg  <= rows_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/yuvcv_line_buf.sv
`default_nettype none

module yuvcv_line_buf
    import yuvcv_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [COL_W-1:0]    wr_addr,
    input  wire logic [CHROMA_W-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [COL_W-1:0]    rd_addr,
    output logic      [CHROMA_W-1:0] rd_data
);

    logic [CHROMA_W-1:0] mem [LINE_DEPTH];
    logic [CHROMA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/yuvcv_out_fifo.sv
`default_nettype none

module yuvcv_out_fifo
    import yuvcv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           full,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    out_item_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/yuv420_to_uyvy_converter.sv
// 4:2:0 planar to packed UYVY converter.
// s_ channel: one pixel pair per transfer in raster order, s_tdata holds two
// luma samples and one Cb/Cr pair (next chroma row on odd rows).
// m_ channel: one UYVY word per input transfer, m_tlast on the last pair of
// a row, m_tuser on the last pair of the frame.
// cfg_ channel: register 0 is frame width, register 1 is frame height;
// write only while the block is idle.
// Even rows store their chroma in a 512-entry line memory; odd rows read the
// stored pair (registered read) and average it with the incoming pair.
// Throughput is one pair per clock while the output buffer is not full. Each
// input pair is registered in the read stage alongside its line memory read,
// then enters the output buffer, which drives m_tvalid.
// Reset sets 320x240, clears the row and column counters and empties the
// pipeline; line memory contents are not cleared, and every odd row reads
// only entries written by the even row before it while the width is unchanged.
// When m_tready is low, the 2-entry output buffer and the read stage absorb
// up to three pairs, then s_tready drops until the receiver takes data.
`default_nettype none

module yuv420_to_uyvy_converter
    import yuvcv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // luma_left, luma_right, chroma_blue, chroma_red
    input  wire logic [TDATA_W-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_cb, out_luma_left, out_cr, out_luma_right
    output logic      [TDATA_W-1:0]    m_tdata,
    output logic                       m_tlast,
    // frame_last
    output logic                       m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    pos_t                pos;
    logic                accept;
    logic                push;
    logic                fifo_full;
    logic [CHROMA_W-1:0] stored;
    out_item_t           push_item;
    out_item_t           out_item;

    logic                s1_valid_reg, s1_valid_next;
    logic [TDATA_W-1:0]  s1_data_reg;
    logic                s1_odd_reg;
    logic                s1_row_last_reg;
    logic                s1_frame_last_reg;

    logic [SAMPLE_W:0]   sum_cb;
    logic [SAMPLE_W:0]   sum_cr;

    assign s_tready = !s1_valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = s1_valid_reg && !fifo_full;

    yuvcv_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    // even rows write, odd rows read: never the same entry in one row
    yuvcv_line_buf u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept && !pos.odd),
        .wr_addr (pos.col),
        .wr_data (s_tdata[TDATA_W-1:2*SAMPLE_W]),
        .rd_en   (accept && pos.odd),
        .rd_addr (pos.col),
        .rd_data (stored)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_data_reg       <= s_tdata;
            s1_odd_reg        <= pos.odd;
            s1_row_last_reg   <= pos.row_last;
            s1_frame_last_reg <= pos.frame_last;
        end
    end

    assign sum_cb = {1'b0, stored[SAMPLE_W-1:0]} +
                    {1'b0, s1_data_reg[3*SAMPLE_W-1:2*SAMPLE_W]};
    assign sum_cr = {1'b0, stored[CHROMA_W-1:SAMPLE_W]} +
                    {1'b0, s1_data_reg[4*SAMPLE_W-1:3*SAMPLE_W]};

    always_comb begin
        push_item.luma_left  = s1_data_reg[SAMPLE_W-1:0];
        push_item.luma_right = s1_data_reg[2*SAMPLE_W-1:SAMPLE_W];
        push_item.row_last   = s1_row_last_reg;
        push_item.frame_last = s1_frame_last_reg;
        if (s1_odd_reg) begin
            push_item.cb = sum_cb[SAMPLE_W:1];
            push_item.cr = sum_cr[SAMPLE_W:1];
        end else begin
            push_item.cb = s1_data_reg[3*SAMPLE_W-1:2*SAMPLE_W];
            push_item.cr = s1_data_reg[4*SAMPLE_W-1:3*SAMPLE_W];
        end
    end

    yuvcv_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {out_item.luma_right, out_item.cr, out_item.luma_left, out_item.cb};
    assign m_tlast = out_item.row_last;
    assign m_tuser = out_item.frame_last;

endmodule

`default_nettype wire

FILE: tb/yuv420_to_uyvy_converter_tb.sv
`default_nettype none

module yuv420_to_uyvy_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yuvcv_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PAIRS  = 1750;
    localparam int IDLE_PCT      = 29;
    localparam int HOLD_AT_WORD  = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int CALM_FROM     = 1200;
    localparam int CALM_TO       = 1450;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // luma_left, luma_right, chroma_blue, chroma_red
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // out_cb, out_luma_left, out_cr, out_luma_right
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    // frame_last
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [TDATA_W-1:0]    pair_queue[$];
    out_item_t             uyvy_expected[$];
    out_item_t             want_word;

    logic [CFG_DATA_W-1:0] width_reg  = 11'(RESET_WIDTH);
    logic [CFG_DATA_W-1:0] height_reg = 11'(RESET_HEIGHT);
    logic [15:0]           line_chroma[LINE_DEPTH];
    int                    col_pos    = 0;
    int                    row_pos    = 0;

    int                    mismatches   = 0;
    int                    pairs_sent   = 0;
    int                    words_taken  = 0;
    int                    hold_left    = 0;
    bit                    hold_done    = 1'b0;
    int                    stall_cycles = 0;

    yuv420_to_uyvy_converter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int row_pairs();
        int w;
        w = int'(width_reg) - int'(width_reg) % 16;
        if (w < MIN_WIDTH) begin
            w = MIN_WIDTH;
        end else if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        return w / 2;
    endfunction

    function automatic int frame_rows();
        int h;
        h = int'(height_reg) - int'(height_reg) % 2;
        if (h < MIN_HEIGHT) begin
            h = MIN_HEIGHT;
        end else if (h > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
        end
        return h;
    endfunction

    // pairs still to come before the current frame closes
    function automatic int frame_left();
        int pairs;
        int rows;
        int in_row;
        int rows_after;
        pairs = row_pairs();
        rows = frame_rows();
        in_row = (col_pos + 1 >= pairs) ? 1 : pairs - col_pos;
        rows_after = (row_pos + 1 >= rows) ? 0 : rows - row_pos - 1;
        return in_row + rows_after * pairs;
    endfunction

    function automatic out_item_t convert_pair(input logic [TDATA_W-1:0] pair);
        out_item_t   word;
        logic [7:0]  yl;
        logic [7:0]  yr;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic [15:0] stored;
        int          pairs;
        int          rows;
        {cr, cb, yr, yl} = pair;
        pairs = row_pairs();
        rows = frame_rows();
        if (row_pos % 2 == 0) begin
            line_chroma[col_pos] = {cr, cb};
            word.cb = cb;
            word.cr = cr;
        end else begin
            stored = line_chroma[col_pos];
            word.cb = 8'((int'(stored[7:0]) + int'(cb)) / 2);
            word.cr = 8'((int'(stored[15:8]) + int'(cr)) / 2);
        end
        word.luma_left  = yl;
        word.luma_right = yr;
        word.row_last   = (col_pos + 1 >= pairs);
        word.frame_last = word.row_last && (row_pos + 1 >= rows);
        if (word.row_last) begin
            col_pos = 0;
            row_pos = word.frame_last ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return word;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                pairs_sent++;
            end
            if (pair_queue.size() > 0 && ((pairs_sent >= CALM_FROM && pairs_sent < CALM_TO) ||
                                          $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pair_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side, with one long hold-off to back up the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (words_taken >= CALM_FROM && words_taken < CALM_TO) ||
                            $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // prediction and comparison
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (uyvy_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: word expected none, actual %h last %b user %b",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    want_word = uyvy_expected.pop_front();
                    check_field("out_cb", want_word.cb, m_tdata[7:0]);
                    check_field("out_luma_left", want_word.luma_left, m_tdata[15:8]);
                    check_field("out_cr", want_word.cr, m_tdata[23:16]);
                    check_field("out_luma_right", want_word.luma_right, m_tdata[31:24]);
                    check_field("row_last", want_word.row_last, m_tlast);
                    check_field("frame_last", want_word.frame_last, m_tuser);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = cfg_data;
                end else if (cfg_index == CFG_FRAME_HEIGHT) begin
                    height_reg = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                uyvy_expected.push_back(convert_pair(s_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("yuv420_to_uyvy_converter_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pair_queue.size() > 0 || s_tvalid || uyvy_expected.size() > 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 11'($urandom_range(1, 4) * 16 + $urandom_range(0, 15));
            6:                return 11'($urandom_range(0, 15));
            7:                return '1;
            default:          return 11'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 11'($urandom_range(2, 8));
            6:                return 11'($urandom_range(0, 1));
            7:                return '1;
            default:          return 11'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] ext_vals[8];
        int         random_pairs;
        int         n;
        ext_vals = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd255};
        random_pairs = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 32 wide with ignored low bits, height 1 clamps to 2
        write_reg(CFG_FRAME_WIDTH, 11'd47);
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
        for (int c = 0; c < 10; c++) begin
            pair_queue.push_back({ext_vals[(c + 1) % 8], ext_vals[(c + 5) % 8],
                                  ext_vals[(c + 3) % 8], ext_vals[c % 8]});
        end
        drain();
        // shrink mid-row: column already past the new row end
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        pair_queue.push_back({ext_vals[3], ext_vals[7], ext_vals[5], ext_vals[2]});
        for (int c = 0; c < 8; c++) begin
            pair_queue.push_back({ext_vals[(c + 2) % 8], ext_vals[(c + 5) % 8],
                                  ext_vals[(c + 6) % 8], ext_vals[(c + 4) % 8]});
        end
        drain();

        // full-width frame fills the whole line memory
        write_reg(CFG_FRAME_WIDTH, 11'(MAX_WIDTH + $urandom_range(0, 15)));
        write_reg(CFG_FRAME_HEIGHT, 11'(2 + $urandom_range(0, 1)));
        n = frame_left();
        repeat (n) pair_queue.push_back($urandom);
        random_pairs += n;

        while (random_pairs < RANDOM_PAIRS) begin
            drain();
            if ($urandom_range(0, 9) < 6) begin
                write_reg(CFG_FRAME_WIDTH, pick_width());
            end
            if ($urandom_range(0, 9) < 6) begin
                write_reg(CFG_FRAME_HEIGHT, pick_height());
            end
            if ($urandom_range(0, 1) == 1 && frame_left() <= 200) begin
                n = frame_left();
            end else begin
                n = $urandom_range(1, 48);
            end
            repeat (n) pair_queue.push_back($urandom);
            random_pairs += n;
        end

        drain();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && uyvy_expected.size() == 0) begin
            $display("yuv420_to_uyvy_converter_tb passed");
        end else begin
            $display("yuv420_to_uyvy_converter_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
